// ===== sv/aor_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aor_pkg: shared types and constants of the box overlap resolver
// Field widths of the Q15.8 coordinates, the request and response payloads
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aor_pkg;

   // coordinate formats
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 8;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int TWICE_BITS = COORD_BITS + 2;
   localparam int SPEED_BITS = COORD_BITS;
   localparam int SUM_BITS   = SPEED_BITS + 1;

   // split divider: dividend is depth * speed plus half the speed sum
   localparam int PROD_BITS  = SIZE_BITS + SPEED_BITS;
   localparam int NUM_BITS   = PROD_BITS + 1;
   localparam int QUO_BITS   = SIZE_BITS;
   localparam int DIV_STEPS  = QUO_BITS;
   localparam int CNT_BITS   = $clog2(DIV_STEPS);

   // request opcodes
   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   typedef struct packed {
      logic                         op;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic        [SIZE_BITS-1:0]  size_w;
      logic        [SIZE_BITS-1:0]  size_h;
      logic signed [COORD_BITS-1:0] vel_x;
      logic signed [COORD_BITS-1:0] vel_y;
      logic                         movable;
   } req_payload_type;

   typedef struct packed {
      logic                         along_x;
      logic signed [COORD_BITS-1:0] shift_first;
      logic signed [COORD_BITS-1:0] shift_second;
      logic                         stop_first;
      logic                         stop_second;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load_held;
      logic load_second;
      logic calc_edge;
      logic calc_axis;
      logic calc_sel;
      logic calc_mul;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ===== sv/aor_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aor_if: request and response channels of the box overlap resolver
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------

// request channel: one box per request
interface aor_req_if import aor_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic        [SIZE_BITS-1:0]  size_w;
   logic        [SIZE_BITS-1:0]  size_h;
   logic signed [COORD_BITS-1:0] vel_x;
   logic signed [COORD_BITS-1:0] vel_y;
   logic                         movable;

   modport source (
      output valid, op, pos_x, pos_y, size_w, size_h, vel_x, vel_y, movable,
      input  ready
   );
   modport sink (
      input  valid, op, pos_x, pos_y, size_w, size_h, vel_x, vel_y, movable,
      output ready
   );
endinterface

// response channel: one resolution per resolve request
interface aor_rsp_if import aor_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         along_x;
   logic signed [COORD_BITS-1:0] shift_first;
   logic signed [COORD_BITS-1:0] shift_second;
   logic                         stop_first;
   logic                         stop_second;

   modport source (
      output valid, along_x, shift_first, shift_second, stop_first, stop_second,
      input  ready
   );
   modport sink (
      input  valid, along_x, shift_first, shift_second, stop_first, stop_second,
      output ready
   );
endinterface

// ===== sv/aor_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aor_datapath: box registers, intersection, axis choice and split divider
// Stores the first box, then works a resolve request through edge, axis,
// select and multiply registers and a radix-2 restoring divider, and holds
// the response payload register.
// ----------------------------------------------------------------------------
module aor_datapath import aor_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  req_payload_type req_data,
   output status_type      status,
   output rsp_payload_type rsp_data
);

   // magnitude of a signed speed, fits unsigned at the same width
   function automatic logic [SPEED_BITS-1:0] speed_mag(input logic signed [COORD_BITS-1:0] v);
      logic [SPEED_BITS-1:0] m;
      m = v[COORD_BITS-1] ? SPEED_BITS'(-v) : SPEED_BITS'(v);
      return m;
   endfunction

   // twice the centre: 2*lo + len
   function automatic logic signed [TWICE_BITS-1:0] twice_centre(
      input logic signed [COORD_BITS-1:0] lo,
      input logic        [SIZE_BITS-1:0]  len
   );
      logic signed [TWICE_BITS-1:0] t;
      t = $signed({lo[COORD_BITS-1], lo, 1'b0}) + $signed({3'b000, len});
      return t;
   endfunction

   // first box (state)
   logic signed [COORD_BITS-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic        [SIZE_BITS-1:0]  w1_ff, w1_in, h1_ff, h1_in;
   logic signed [COORD_BITS-1:0] vx1_ff, vx1_in, vy1_ff, vy1_in;
   logic                         mv1_ff, mv1_in;

   // second box
   logic signed [COORD_BITS-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic        [SIZE_BITS-1:0]  w2_ff, w2_in, h2_ff, h2_in;
   logic signed [COORD_BITS-1:0] vx2_ff, vx2_in, vy2_ff, vy2_in;
   logic                         mv2_ff, mv2_in;

   // intersection edges
   logic signed [COORD_BITS-1:0] left_ff, left_in, top_ff, top_in;
   logic signed [EDGE_BITS-1:0]  right_ff, right_in, bottom_ff, bottom_in;

   // intersection box
   logic        [SIZE_BITS-1:0]  cw_ff, cw_in, ch_ff, ch_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;

   // chosen axis operands
   logic                         ax_ff, ax_in;
   logic        [SIZE_BITS-1:0]  depth_ff, depth_in, clen_ff, clen_in;
   logic signed [COORD_BITS-1:0] clo_ff, clo_in, lo1_ff, lo1_in, lo2_ff, lo2_in;
   logic        [SIZE_BITS-1:0]  len1_ff, len1_in, len2_ff, len2_in;
   logic        [SPEED_BITS-1:0] spd_a_ff, spd_a_in, spd_b_ff, spd_b_in;

   // product, speed sum and push directions
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                 neg1_ff, neg1_in, neg2_ff, neg2_in;

   // divider
   logic [SUM_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // response payload
   rsp_payload_type out_ff, out_in;

   // combinational helpers
   logic signed [EDGE_BITS-1:0]  r1, r2, b1, b2;
   logic signed [EDGE_BITS-1:0]  left_ext, top_ext, cw_full, ch_full;
   logic                         overlap;
   logic [NUM_BITS-1:0]          num;
   logic [SUM_BITS:0]            trial;
   logic [SUM_BITS:0]            rem_shift;
   logic [SIZE_BITS:0]           depth_inc;
   logic [SIZE_BITS-1:0]         half, part1, part2, mag1, mag2;
   logic                         both, sneg2;
   logic signed [COORD_BITS-1:0] s1_pos, s2_pos;

   // far edges of both boxes
   assign r1 = $signed({x1_ff[COORD_BITS-1], x1_ff}) + $signed({2'b00, w1_ff});
   assign r2 = $signed({x2_ff[COORD_BITS-1], x2_ff}) + $signed({2'b00, w2_ff});
   assign b1 = $signed({y1_ff[COORD_BITS-1], y1_ff}) + $signed({2'b00, h1_ff});
   assign b2 = $signed({y2_ff[COORD_BITS-1], y2_ff}) + $signed({2'b00, h2_ff});

   // intersection extents
   assign left_ext = $signed({left_ff[COORD_BITS-1], left_ff});
   assign top_ext  = $signed({top_ff[COORD_BITS-1], top_ff});
   assign cw_full  = right_ff - left_ext;
   assign ch_full  = bottom_ff - top_ext;
   assign overlap  = (left_ext < right_ff) && (top_ext < bottom_ff);

   // divider step
   assign num       = NUM_BITS'(prod_ff) + NUM_BITS'(sum_ff[SUM_BITS-1:1]);
   assign rem_shift = {rem_ff, dvd_ff[QUO_BITS-1]};
   assign trial     = rem_shift - {1'b0, sum_ff};

   // split into the two shifts
   assign both      = mv1_ff & mv2_ff;
   assign depth_inc = {1'b0, depth_ff} + (SIZE_BITS+1)'(1);
   assign half      = depth_inc[SIZE_BITS:1];
   assign part1     = (sum_ff == '0) ? half : quo_ff;
   assign part2     = depth_ff - part1;
   assign mag1      = both ? part1 : depth_ff;
   assign mag2      = both ? part2 : depth_ff;
   assign sneg2     = both ? ~neg1_ff : neg2_ff;
   assign s1_pos    = $signed({1'b0, mag1});
   assign s2_pos    = $signed({1'b0, mag2});

   // next values
   always_comb begin
      x1_in = x1_ff;   y1_in = y1_ff;   w1_in = w1_ff;   h1_in = h1_ff;
      vx1_in = vx1_ff; vy1_in = vy1_ff; mv1_in = mv1_ff;
      x2_in = x2_ff;   y2_in = y2_ff;   w2_in = w2_ff;   h2_in = h2_ff;
      vx2_in = vx2_ff; vy2_in = vy2_ff; mv2_in = mv2_ff;
      left_in = left_ff; right_in = right_ff; top_in = top_ff; bottom_in = bottom_ff;
      cw_in = cw_ff; ch_in = ch_ff; cx_in = cx_ff; cy_in = cy_ff;
      ax_in = ax_ff; depth_in = depth_ff; clo_in = clo_ff; clen_in = clen_ff;
      lo1_in = lo1_ff; lo2_in = lo2_ff; len1_in = len1_ff; len2_in = len2_ff;
      spd_a_in = spd_a_ff; spd_b_in = spd_b_ff;
      prod_in = prod_ff; sum_in = sum_ff; neg1_in = neg1_ff; neg2_in = neg2_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      out_in = out_ff;

      // store first box
      if (cmd.load_held) begin
         x1_in  = req_data.pos_x;  y1_in  = req_data.pos_y;
         w1_in  = req_data.size_w; h1_in  = req_data.size_h;
         vx1_in = req_data.vel_x;  vy1_in = req_data.vel_y;
         mv1_in = req_data.movable;
      end

      // capture second box
      if (cmd.load_second) begin
         x2_in  = req_data.pos_x;  y2_in  = req_data.pos_y;
         w2_in  = req_data.size_w; h2_in  = req_data.size_h;
         vx2_in = req_data.vel_x;  vy2_in = req_data.vel_y;
         mv2_in = req_data.movable;
      end

      // intersection edges
      if (cmd.calc_edge) begin
         left_in   = (x1_ff > x2_ff) ? x1_ff : x2_ff;
         top_in    = (y1_ff > y2_ff) ? y1_ff : y2_ff;
         right_in  = (r1 < r2) ? r1 : r2;
         bottom_in = (b1 < b2) ? b1 : b2;
      end

      // intersection box, all zero without overlap
      if (cmd.calc_axis) begin
         if (overlap) begin
            cw_in = cw_full[SIZE_BITS-1:0];
            ch_in = ch_full[SIZE_BITS-1:0];
            cx_in = left_ff;
            cy_in = top_ff;
         end else begin
            cw_in = '0;
            ch_in = '0;
            cx_in = '0;
            cy_in = '0;
         end
      end

      // axis choice: y when wider than tall
      if (cmd.calc_sel) begin
         ax_in = ~(cw_ff > ch_ff);
         if (ax_in) begin
            depth_in = cw_ff;  clo_in = cx_ff;  clen_in = cw_ff;
            lo1_in = x1_ff;    len1_in = w1_ff; lo2_in = x2_ff; len2_in = w2_ff;
            spd_a_in = speed_mag(vx1_ff);
            spd_b_in = speed_mag(vx2_ff);
         end else begin
            depth_in = ch_ff;  clo_in = cy_ff;  clen_in = ch_ff;
            lo1_in = y1_ff;    len1_in = h1_ff; lo2_in = y2_ff; len2_in = h2_ff;
            spd_a_in = speed_mag(vy1_ff);
            spd_b_in = speed_mag(vy2_ff);
         end
      end

      // weighted depth, speed sum and push directions
      if (cmd.calc_mul) begin
         prod_in = PROD_BITS'(depth_ff) * PROD_BITS'(spd_a_ff);
         sum_in  = {1'b0, spd_a_ff} + {1'b0, spd_b_ff};
         neg1_in = twice_centre(lo1_ff, len1_ff) < twice_centre(clo_ff, clen_ff);
         neg2_in = twice_centre(lo2_ff, len2_ff) < twice_centre(clo_ff, clen_ff);
      end

      // load divider, upper part is already below the divisor
      if (cmd.div_init) begin
         rem_in = num[NUM_BITS-1:QUO_BITS];
         dvd_in = num[QUO_BITS-1:0];
         quo_in = '0;
         cnt_in = '0;
      end

      // one quotient bit per step
      if (cmd.div_step) begin
         if (!trial[SUM_BITS]) begin
            rem_in = trial[SUM_BITS-1:0];
         end else begin
            rem_in = rem_shift[SUM_BITS-1:0];
         end
         dvd_in = {dvd_ff[QUO_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], ~trial[SUM_BITS]};
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      // response payload
      if (cmd.load_out) begin
         out_in.along_x      = ax_ff;
         out_in.shift_first  = mv1_ff ? (neg1_ff ? -s1_pos : s1_pos) : '0;
         out_in.shift_second = mv2_ff ? (sneg2 ? -s2_pos : s2_pos) : '0;
         out_in.stop_first   = mv1_ff;
         out_in.stop_second  = mv2_ff;
      end
   end

   // first box state
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff  <= '0; y1_ff  <= '0; w1_ff <= '0; h1_ff <= '0;
         vx1_ff <= '0; vy1_ff <= '0; mv1_ff <= 1'b0;
      end else begin
         x1_ff  <= x1_in;  y1_ff  <= y1_in;  w1_ff <= w1_in; h1_ff <= h1_in;
         vx1_ff <= vx1_in; vy1_ff <= vy1_in; mv1_ff <= mv1_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      x2_ff  <= x2_in;  y2_ff  <= y2_in;  w2_ff <= w2_in; h2_ff <= h2_in;
      vx2_ff <= vx2_in; vy2_ff <= vy2_in; mv2_ff <= mv2_in;
      left_ff <= left_in; right_ff <= right_in; top_ff <= top_in; bottom_ff <= bottom_in;
      cw_ff <= cw_in; ch_ff <= ch_in; cx_ff <= cx_in; cy_ff <= cy_in;
      ax_ff <= ax_in; depth_ff <= depth_in; clo_ff <= clo_in; clen_ff <= clen_in;
      lo1_ff <= lo1_in; lo2_ff <= lo2_in; len1_ff <= len1_in; len2_ff <= len2_in;
      spd_a_ff <= spd_a_in; spd_b_ff <= spd_b_in;
      prod_ff <= prod_in; sum_ff <= sum_in; neg1_ff <= neg1_in; neg2_ff <= neg2_in;
      rem_ff <= rem_in; dvd_ff <= dvd_in; quo_ff <= quo_in;
      out_ff <= out_in;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.div_last = (cnt_ff == CNT_BITS'(DIV_STEPS - 1));
   assign rsp_data        = out_ff;

endmodule

// ===== sv/aor_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aor_ctrl: sequencer of the box overlap resolver
// Takes requests, steps the datapath through a resolve and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module aor_ctrl import aor_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EDGE  = 3'd1;
   localparam logic [2:0] ST_AXIS  = 3'd2;
   localparam logic [2:0] ST_SEL   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DINIT = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire, out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_STORE) begin
                  cmd.load_held = 1'b1;
               end else begin
                  cmd.load_second = 1'b1;
                  state_in        = ST_EDGE;
               end
            end
         end
         ST_EDGE: begin
            cmd.calc_edge = 1'b1;
            state_in      = ST_AXIS;
         end
         ST_AXIS: begin
            cmd.calc_axis = 1'b1;
            state_in      = ST_SEL;
         end
         ST_SEL: begin
            cmd.calc_sel = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait here while an older response is still pending
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while pending");

   // a new response is always shown the next cycle
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded response not valid");

   // a resolve request starts the sequence
   a_resolve_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_RESOLVE) |=> (state_ff == ST_EDGE))
      else $error("resolve request did not start");

   // divider leaves after its last step
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_FIN))
      else $error("divider did not finish");

   // at most one of the loads of the box and output registers per cycle
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_held, cmd.load_second, cmd.load_out}))
      else $error("conflicting register loads");

endmodule

// ===== sv/aabb_overlap_resolver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_resolver_unit: top level of the box overlap resolver
// Pushes two overlapping axis-aligned boxes apart along one axis, sharing
// the depth between movable boxes in proportion to their speeds.
//
//   channel   direction  contents
//   req_bus   in         op, box position, size, velocity, movable flag
//   rsp_bus   out        axis, shifts of both boxes, stop flags
//
// a store request (op 0) loads the first box and produces no response
// a resolve request (op 1) steps through the edge, axis, select, multiply,
// divider load and radix-2 restoring divider states, then raises valid
// the next request is taken right after, even while the response waits
// a response waiting for ready holds only a following resolve at its end
// synchronous reset clears the stored first box and the control state
// ----------------------------------------------------------------------------
module aabb_overlap_resolver_unit import aor_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   aor_req_if.sink   req_bus,
   aor_rsp_if.source rsp_bus
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   // request payload bundle
   assign req_data.op      = req_bus.op;
   assign req_data.pos_x   = req_bus.pos_x;
   assign req_data.pos_y   = req_bus.pos_y;
   assign req_data.size_w  = req_bus.size_w;
   assign req_data.size_h  = req_bus.size_h;
   assign req_data.vel_x   = req_bus.vel_x;
   assign req_data.vel_y   = req_bus.vel_y;
   assign req_data.movable = req_bus.movable;

   // sequencer
   aor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   aor_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // response payload
   assign rsp_bus.along_x      = rsp_data.along_x;
   assign rsp_bus.shift_first  = rsp_data.shift_first;
   assign rsp_bus.shift_second = rsp_data.shift_second;
   assign rsp_bus.stop_first   = rsp_data.stop_first;
   assign rsp_bus.stop_second  = rsp_data.stop_second;

endmodule
